[hdl/c_minus_token_scanner_macros.svh]
// assertion macros shared by the token scanner rtl
`ifndef C_MINUS_TOKEN_SCANNER_MACROS_SVH
`define C_MINUS_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define CMTS_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("token scanner check failed");
// next-cycle implication, held off during reset
`define CMTS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("token scanner check failed");
`else
`define CMTS_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define CMTS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[hdl/cmts_pkg.sv]
// types, codes and helper functions of the token scanner
package cmts_pkg;

  localparam int NUM_BITS_DEF      = 32;
  localparam int LINE_BITS_DEF     = 16;
  localparam int COL_BITS_DEF      = 12;
  localparam int KEYWORD_CHARS_DEF = 6;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [3:0] {
    MODE_START,
    MODE_ID,
    MODE_NUM,
    MODE_MINUS,
    MODE_PLUS,
    MODE_LT,
    MODE_GT,
    MODE_EQ,
    MODE_BANG,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BLOCK_STAR
  } mode_t;

  // which result slots a step fills; the second implies the first
  typedef struct packed {
    logic slot0;
    logic slot1;
  } emit_t;

  // token kinds
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_ERROR    = 5'd1;
  localparam logic [4:0] KIND_ID       = 5'd2;
  localparam logic [4:0] KIND_NUM      = 5'd3;
  localparam logic [4:0] KIND_IF       = 5'd4;
  localparam logic [4:0] KIND_SEMI     = 5'd10;
  localparam logic [4:0] KIND_COMMA    = 5'd11;
  localparam logic [4:0] KIND_LPAREN   = 5'd12;
  localparam logic [4:0] KIND_RPAREN   = 5'd13;
  localparam logic [4:0] KIND_LBRACKET = 5'd14;
  localparam logic [4:0] KIND_RBRACKET = 5'd15;
  localparam logic [4:0] KIND_LBRACE   = 5'd16;
  localparam logic [4:0] KIND_RBRACE   = 5'd17;
  localparam logic [4:0] KIND_MINUS    = 5'd18;
  localparam logic [4:0] KIND_DEC      = 5'd19;
  localparam logic [4:0] KIND_PLUS     = 5'd20;
  localparam logic [4:0] KIND_INC      = 5'd21;
  localparam logic [4:0] KIND_STAR     = 5'd22;
  localparam logic [4:0] KIND_SLASH    = 5'd23;
  localparam logic [4:0] KIND_LT       = 5'd24;
  localparam logic [4:0] KIND_LE       = 5'd25;
  localparam logic [4:0] KIND_GT       = 5'd26;
  localparam logic [4:0] KIND_GE       = 5'd27;
  localparam logic [4:0] KIND_ASSIGN   = 5'd28;
  localparam logic [4:0] KIND_EQ       = 5'd29;
  localparam logic [4:0] KIND_NE       = 5'd30;

  // source characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // keywords packed first character highest: if else int void return while
  localparam int KW_COUNT = 6;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h000000006966,
    48'h0000656C7365,
    48'h000000696E74,
    48'h0000766F6964,
    48'h72657475726E,
    48'h007768696C65
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd2, 8'd4, 8'd3, 8'd4, 8'd6, 8'd5};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // space and tab through return
  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // keyword kind of a short identifier, else identifier
  function automatic logic [4:0] keyword_kind(input logic [63:0] word, input logic [7:0] len);
    logic [4:0] kind;
    kind = KIND_ID;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (word == 64'(KW_TEXT[k]) && len == KW_LEN[k]) begin
        kind = KIND_IF + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

[hdl/cmts_byte_if.sv]
// request channel carrying one source byte or the end marker
interface cmts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink (input valid, input ch, input at_end, output ready);
endinterface

[hdl/cmts_tok_if.sv]
// request channel carrying one finished token
interface cmts_tok_if #(
  parameter int NUM_BITS  = cmts_pkg::NUM_BITS_DEF,
  parameter int LINE_BITS = cmts_pkg::LINE_BITS_DEF,
  parameter int COL_BITS  = cmts_pkg::COL_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           kind;
  logic [NUM_BITS-1:0]  number;
  logic                 overflowed;
  logic [7:0]           length;
  logic [LINE_BITS-1:0] line;
  logic [COL_BITS-1:0]  column;
  logic                 last;

  modport source (
    output valid, output kind, output number, output overflowed, output length,
    output line, output column, output last, input ready
  );
  modport sink (
    input valid, input kind, input number, input overflowed, input length,
    input line, input column, input last, output ready
  );
endinterface

[hdl/cmts_step.sv]
// next-state and token logic for one source byte
module cmts_step #(
  parameter int NUM_BITS      = cmts_pkg::NUM_BITS_DEF,
  parameter int LINE_BITS     = cmts_pkg::LINE_BITS_DEF,
  parameter int COL_BITS      = cmts_pkg::COL_BITS_DEF,
  parameter int KEYWORD_CHARS = cmts_pkg::KEYWORD_CHARS_DEF
) (
  input  logic [7:0]                 ch,
  input  logic                       at_end,
  input  cmts_pkg::mode_t            mode,
  input  logic [LINE_BITS-1:0]       line,
  input  logic [COL_BITS-1:0]        col,
  input  logic [8*KEYWORD_CHARS-1:0] kw_word,
  input  logic [7:0]                 lex_len,
  input  logic [NUM_BITS-1:0]        acc,
  input  logic                       acc_ovf,
  output cmts_pkg::mode_t            mode_nxt,
  output logic [LINE_BITS-1:0]       line_nxt,
  output logic [COL_BITS-1:0]        col_nxt,
  output logic [8*KEYWORD_CHARS-1:0] kw_word_nxt,
  output logic [7:0]                 lex_len_nxt,
  output logic [NUM_BITS-1:0]        acc_nxt,
  output logic                       acc_ovf_nxt,
  output cmts_pkg::emit_t            emit,
  output logic [4:0]                 tok_kind [2],
  output logic [NUM_BITS-1:0]        tok_number [2],
  output logic                       tok_ovf [2],
  output logic [7:0]                 tok_length [2],
  output logic [COL_BITS-1:0]        tok_column [2],
  output logic                       tok_last [2]
);

  logic [COL_BITS-1:0]  col_inc;
  logic [LINE_BITS-1:0] line_inc;
  logic [7:0]           len_inc;
  logic [NUM_BITS+3:0]  digit_wide;
  logic                 digit_sat;

  logic                fl_vld;
  logic                fl_take;
  logic [4:0]          fl_kind;
  logic [NUM_BITS-1:0] fl_number;
  logic                fl_ovf;
  logic [7:0]          fl_length;

  logic                sb_vld;
  logic [4:0]          sb_kind;
  logic [7:0]          sb_length;
  logic [COL_BITS-1:0] sb_col;

  logic       done;
  logic       newline;
  logic       single;
  logic [7:0] pair_want;
  logic [4:0] pair_kind;

  assign col_inc  = col + 1'b1;
  assign line_inc = (line == '1) ? line : line + 1'b1;
  assign len_inc  = (lex_len == 8'hFF) ? lex_len : lex_len + 8'd1;

  // acc * 10 + digit, saturating when it no longer fits
  assign digit_wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                    + {{NUM_BITS{1'b0}}, ch[3:0]};
  assign digit_sat  = |digit_wide[NUM_BITS+3:NUM_BITS];

  // pending token held by the mode
  always_comb begin
    fl_vld    = 1'b1;
    fl_kind   = cmts_pkg::KIND_END;
    fl_number = '0;
    fl_ovf    = 1'b0;
    fl_length = 8'd1;
    unique case (mode)
      cmts_pkg::MODE_ID: begin
        fl_kind   = (lex_len > 8'(KEYWORD_CHARS)) ? cmts_pkg::KIND_ID
                  : cmts_pkg::keyword_kind(64'(kw_word), lex_len);
        fl_length = lex_len;
      end
      cmts_pkg::MODE_NUM: begin
        fl_kind   = cmts_pkg::KIND_NUM;
        fl_number = acc;
        fl_ovf    = acc_ovf;
        fl_length = lex_len;
      end
      cmts_pkg::MODE_MINUS: fl_kind = cmts_pkg::KIND_MINUS;
      cmts_pkg::MODE_PLUS:  fl_kind = cmts_pkg::KIND_PLUS;
      cmts_pkg::MODE_LT:    fl_kind = cmts_pkg::KIND_LT;
      cmts_pkg::MODE_GT:    fl_kind = cmts_pkg::KIND_GT;
      cmts_pkg::MODE_EQ:    fl_kind = cmts_pkg::KIND_ASSIGN;
      cmts_pkg::MODE_BANG:  fl_kind = cmts_pkg::KIND_ERROR;
      cmts_pkg::MODE_SLASH: fl_kind = cmts_pkg::KIND_SLASH;
      default:              fl_vld  = 1'b0;
    endcase
  end

  // second character that completes a two-character operator
  always_comb begin
    pair_want = cmts_pkg::CH_EQ;
    pair_kind = cmts_pkg::KIND_ERROR;
    unique case (mode)
      cmts_pkg::MODE_MINUS: begin
        pair_want = cmts_pkg::CH_MINUS;
        pair_kind = cmts_pkg::KIND_DEC;
      end
      cmts_pkg::MODE_PLUS: begin
        pair_want = cmts_pkg::CH_PLUS;
        pair_kind = cmts_pkg::KIND_INC;
      end
      cmts_pkg::MODE_LT:   pair_kind = cmts_pkg::KIND_LE;
      cmts_pkg::MODE_GT:   pair_kind = cmts_pkg::KIND_GE;
      cmts_pkg::MODE_EQ:   pair_kind = cmts_pkg::KIND_EQ;
      cmts_pkg::MODE_BANG: pair_kind = cmts_pkg::KIND_NE;
      default:             pair_kind = cmts_pkg::KIND_ERROR;
    endcase
  end

  always_comb begin
    mode_nxt    = mode;
    line_nxt    = line;
    col_nxt     = col;
    kw_word_nxt = kw_word;
    lex_len_nxt = lex_len;
    acc_nxt     = acc;
    acc_ovf_nxt = acc_ovf;
    fl_take     = 1'b0;
    sb_vld      = 1'b0;
    sb_kind     = cmts_pkg::KIND_END;
    sb_length   = 8'd1;
    sb_col      = col_inc;
    done        = 1'b0;
    newline     = 1'b0;
    single      = 1'b0;

    if (at_end) begin
      // flush, end token, back to the reset state
      fl_take     = fl_vld;
      sb_vld      = 1'b1;
      sb_length   = 8'd0;
      sb_col      = col;
      mode_nxt    = cmts_pkg::MODE_START;
      line_nxt    = LINE_BITS'(1);
      col_nxt     = '1;
      kw_word_nxt = '0;
      lex_len_nxt = 8'd0;
      acc_nxt     = '0;
      acc_ovf_nxt = 1'b0;
    end else begin
      col_nxt = col_inc;
      unique case (mode) inside
        cmts_pkg::MODE_ID: begin
          if (cmts_pkg::is_alpha(ch) || cmts_pkg::is_digit(ch)) begin
            if (lex_len < 8'(KEYWORD_CHARS)) begin
              kw_word_nxt = {kw_word[8*KEYWORD_CHARS-9:0], ch};
            end
            lex_len_nxt = len_inc;
            done        = 1'b1;
          end
        end
        cmts_pkg::MODE_NUM: begin
          if (cmts_pkg::is_digit(ch)) begin
            acc_nxt     = digit_sat ? '1 : digit_wide[NUM_BITS-1:0];
            acc_ovf_nxt = acc_ovf | digit_sat;
            lex_len_nxt = len_inc;
            done        = 1'b1;
          end
        end
        cmts_pkg::MODE_MINUS, cmts_pkg::MODE_PLUS, cmts_pkg::MODE_LT,
        cmts_pkg::MODE_GT, cmts_pkg::MODE_EQ, cmts_pkg::MODE_BANG: begin
          if (ch == pair_want) begin
            sb_vld    = 1'b1;
            sb_kind   = pair_kind;
            sb_length = 8'd2;
            mode_nxt  = cmts_pkg::MODE_START;
            done      = 1'b1;
          end
        end
        cmts_pkg::MODE_SLASH: begin
          if (ch == cmts_pkg::CH_STAR) begin
            mode_nxt = cmts_pkg::MODE_BLOCK;
            done     = 1'b1;
          end else if (ch == cmts_pkg::CH_SLASH) begin
            mode_nxt = cmts_pkg::MODE_LINE;
            done     = 1'b1;
          end
        end
        cmts_pkg::MODE_LINE: begin
          done = 1'b1;
          if (ch == cmts_pkg::CH_NL) begin
            newline  = 1'b1;
            mode_nxt = cmts_pkg::MODE_START;
          end
        end
        cmts_pkg::MODE_BLOCK: begin
          done = 1'b1;
          if (ch == cmts_pkg::CH_NL) begin
            newline = 1'b1;
          end else if (ch == cmts_pkg::CH_STAR) begin
            mode_nxt = cmts_pkg::MODE_BLOCK_STAR;
          end
        end
        cmts_pkg::MODE_BLOCK_STAR: begin
          done = 1'b1;
          if (ch == cmts_pkg::CH_SLASH) begin
            mode_nxt = cmts_pkg::MODE_START;
          end else if (ch == cmts_pkg::CH_NL) begin
            newline  = 1'b1;
            mode_nxt = cmts_pkg::MODE_BLOCK;
          end else if (ch != cmts_pkg::CH_STAR) begin
            mode_nxt = cmts_pkg::MODE_BLOCK;
          end
        end
        default: begin
        end
      endcase

      // byte not absorbed: flush pending token, then start fresh on it
      if (!done) begin
        fl_take  = fl_vld;
        mode_nxt = cmts_pkg::MODE_START;
        case (ch)
          cmts_pkg::CH_SEMI: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_SEMI;
          end
          cmts_pkg::CH_COMMA: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_COMMA;
          end
          cmts_pkg::CH_LPAR: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_LPAREN;
          end
          cmts_pkg::CH_RPAR: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_RPAREN;
          end
          cmts_pkg::CH_LBRK: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_LBRACKET;
          end
          cmts_pkg::CH_RBRK: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_RBRACKET;
          end
          cmts_pkg::CH_LBRC: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_LBRACE;
          end
          cmts_pkg::CH_RBRC: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_RBRACE;
          end
          cmts_pkg::CH_STAR: begin
            single  = 1'b1;
            sb_kind = cmts_pkg::KIND_STAR;
          end
          cmts_pkg::CH_MINUS: mode_nxt = cmts_pkg::MODE_MINUS;
          cmts_pkg::CH_PLUS:  mode_nxt = cmts_pkg::MODE_PLUS;
          cmts_pkg::CH_LT:    mode_nxt = cmts_pkg::MODE_LT;
          cmts_pkg::CH_GT:    mode_nxt = cmts_pkg::MODE_GT;
          cmts_pkg::CH_EQ:    mode_nxt = cmts_pkg::MODE_EQ;
          cmts_pkg::CH_BANG:  mode_nxt = cmts_pkg::MODE_BANG;
          cmts_pkg::CH_SLASH: mode_nxt = cmts_pkg::MODE_SLASH;
          default: begin
            if (cmts_pkg::is_space(ch)) begin
              newline = (ch == cmts_pkg::CH_NL);
            end else if (cmts_pkg::is_alpha(ch)) begin
              mode_nxt    = cmts_pkg::MODE_ID;
              lex_len_nxt = 8'd1;
              kw_word_nxt = (8*KEYWORD_CHARS)'(ch);
            end else if (cmts_pkg::is_digit(ch)) begin
              mode_nxt    = cmts_pkg::MODE_NUM;
              lex_len_nxt = 8'd1;
              acc_nxt     = NUM_BITS'(ch[3:0]);
              acc_ovf_nxt = 1'b0;
            end else begin
              single  = 1'b1;
              sb_kind = cmts_pkg::KIND_ERROR;
            end
          end
        endcase
        if (single) begin
          sb_vld = 1'b1;
        end
      end

      if (newline) begin
        line_nxt = line_inc;
        col_nxt  = '1;
      end
    end
  end

  // flushed token goes first, then the token of this byte
  assign emit.slot0 = fl_take | sb_vld;
  assign emit.slot1 = fl_take & sb_vld;

  assign tok_kind[0]   = fl_take ? fl_kind : sb_kind;
  assign tok_number[0] = fl_take ? fl_number : '0;
  assign tok_ovf[0]    = fl_take & fl_ovf;
  assign tok_length[0] = fl_take ? fl_length : sb_length;
  assign tok_column[0] = fl_take ? col : sb_col;
  assign tok_last[0]   = !(fl_take & sb_vld);

  assign tok_kind[1]   = sb_kind;
  assign tok_number[1] = '0;
  assign tok_ovf[1]    = 1'b0;
  assign tok_length[1] = sb_length;
  assign tok_column[1] = sb_col;
  assign tok_last[1]   = 1'b1;

endmodule

[hdl/c_minus_token_scanner.sv]
// top level of the token scanner: byte register, scanner state and token queue
//
// Token scanner for a small C-like language. One source byte (or an end
// marker) is taken per request on in_byte; finished tokens leave on out_tok
// with kind, number value, length, line and the zero-based column of their
// last character. A byte can be taken every cycle while the queue has room:
// it sits in the input register, where a single pass of logic updates the
// scanner state and writes zero, one or two tokens into a four-entry token
// queue. A byte that ends a pending token and is a one-byte token itself
// yields two tokens, and the end marker any flushed token plus the end
// token; the queue drains one token per cycle while out_tok is ready, so
// the sustained rate is one byte per cycle while the token count stays at
// one per byte, and slows to the out_tok rate when the queue holds more than
// two tokens. After the end token all scanner state is back at its reset value.
`include "c_minus_token_scanner_macros.svh"

module c_minus_token_scanner #(
  parameter int NUM_BITS      = cmts_pkg::NUM_BITS_DEF,
  parameter int LINE_BITS     = cmts_pkg::LINE_BITS_DEF,
  parameter int COL_BITS      = cmts_pkg::COL_BITS_DEF,
  parameter int KEYWORD_CHARS = cmts_pkg::KEYWORD_CHARS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cmts_byte_if.sink   in_byte,
  cmts_tok_if.source  out_tok
);

  localparam int PTR_BITS = $clog2(cmts_pkg::FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(cmts_pkg::FIFO_DEPTH + 1);

  // input register
  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       at_end_r;

  // scanner state
  cmts_pkg::mode_t            mode_r, mode_nxt;
  logic [LINE_BITS-1:0]       line_r, line_nxt;
  logic [COL_BITS-1:0]        col_r, col_nxt;
  logic [8*KEYWORD_CHARS-1:0] kw_word_r, kw_word_nxt;
  logic [7:0]                 lex_len_r, lex_len_nxt;
  logic [NUM_BITS-1:0]        acc_r, acc_nxt;
  logic                       acc_ovf_r, acc_ovf_nxt;

  // tokens made by this step
  cmts_pkg::emit_t     emit;
  logic [4:0]          tok_kind [2];
  logic [NUM_BITS-1:0] tok_number [2];
  logic                tok_ovf [2];
  logic [7:0]          tok_length [2];
  logic [COL_BITS-1:0] tok_column [2];
  logic                tok_last [2];

  // token queue
  logic [4:0]           q_kind_r [cmts_pkg::FIFO_DEPTH];
  logic [NUM_BITS-1:0]  q_number_r [cmts_pkg::FIFO_DEPTH];
  logic                 q_ovf_r [cmts_pkg::FIFO_DEPTH];
  logic [7:0]           q_length_r [cmts_pkg::FIFO_DEPTH];
  logic [LINE_BITS-1:0] q_line_r [cmts_pkg::FIFO_DEPTH];
  logic [COL_BITS-1:0]  q_column_r [cmts_pkg::FIFO_DEPTH];
  logic                 q_last_r [cmts_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  fifo_cnt_r, fifo_cnt_nxt, cnt_after_pop, push_n;

  logic pop;
  logic step_go;

  cmts_step #(
    .NUM_BITS      (NUM_BITS),
    .LINE_BITS     (LINE_BITS),
    .COL_BITS      (COL_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_step (
    .ch          (ch_r),
    .at_end      (at_end_r),
    .mode        (mode_r),
    .line        (line_r),
    .col         (col_r),
    .kw_word     (kw_word_r),
    .lex_len     (lex_len_r),
    .acc         (acc_r),
    .acc_ovf     (acc_ovf_r),
    .mode_nxt    (mode_nxt),
    .line_nxt    (line_nxt),
    .col_nxt     (col_nxt),
    .kw_word_nxt (kw_word_nxt),
    .lex_len_nxt (lex_len_nxt),
    .acc_nxt     (acc_nxt),
    .acc_ovf_nxt (acc_ovf_nxt),
    .emit        (emit),
    .tok_kind    (tok_kind),
    .tok_number  (tok_number),
    .tok_ovf     (tok_ovf),
    .tok_length  (tok_length),
    .tok_column  (tok_column),
    .tok_last    (tok_last)
  );

  // output side pops the head of the queue
  assign out_tok.valid      = (fifo_cnt_r != '0);
  assign out_tok.kind       = q_kind_r[rd_ptr_r];
  assign out_tok.number     = q_number_r[rd_ptr_r];
  assign out_tok.overflowed = q_ovf_r[rd_ptr_r];
  assign out_tok.length     = q_length_r[rd_ptr_r];
  assign out_tok.line       = q_line_r[rd_ptr_r];
  assign out_tok.column     = q_column_r[rd_ptr_r];
  assign out_tok.last       = q_last_r[rd_ptr_r];
  assign pop                = out_tok.valid & out_tok.ready;

  // a held byte is processed once the queue has room for two tokens
  assign cnt_after_pop = fifo_cnt_r - CNT_BITS'(pop);
  assign step_go       = in_vld_r && (cnt_after_pop <= CNT_BITS'(cmts_pkg::FIFO_DEPTH - 2));
  assign in_byte.ready = !in_vld_r || step_go;

  assign push_n       = step_go ? CNT_BITS'(emit.slot0) + CNT_BITS'(emit.slot1) : '0;
  assign fifo_cnt_nxt = cnt_after_pop + push_n;
  assign wr_ptr_p1    = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt   = wr_ptr_r + PTR_BITS'(push_n);
  assign rd_ptr_nxt   = rd_ptr_r + PTR_BITS'(pop);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (in_byte.valid && in_byte.ready) begin
        in_vld_r <= 1'b1;
      end else if (step_go) begin
        in_vld_r <= 1'b0;
      end
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  // scanner state advances once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= cmts_pkg::MODE_START;
      line_r    <= LINE_BITS'(1);
      col_r     <= '1;
      kw_word_r <= '0;
      lex_len_r <= 8'd0;
      acc_r     <= '0;
      acc_ovf_r <= 1'b0;
    end else if (step_go) begin
      mode_r    <= mode_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      kw_word_r <= kw_word_nxt;
      lex_len_r <= lex_len_nxt;
      acc_r     <= acc_nxt;
      acc_ovf_r <= acc_ovf_nxt;
    end
  end

  // input byte register, payload only
  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      ch_r     <= in_byte.ch;
      at_end_r <= in_byte.at_end;
    end
  end

  // queue writes: first token at the tail, second right behind it
  always_ff @(posedge clk) begin
    if (step_go && emit.slot0) begin
      q_kind_r[wr_ptr_r]   <= tok_kind[0];
      q_number_r[wr_ptr_r] <= tok_number[0];
      q_ovf_r[wr_ptr_r]    <= tok_ovf[0];
      q_length_r[wr_ptr_r] <= tok_length[0];
      q_line_r[wr_ptr_r]   <= line_r;
      q_column_r[wr_ptr_r] <= tok_column[0];
      q_last_r[wr_ptr_r]   <= tok_last[0];
    end
    if (step_go && emit.slot1) begin
      q_kind_r[wr_ptr_p1]   <= tok_kind[1];
      q_number_r[wr_ptr_p1] <= tok_number[1];
      q_ovf_r[wr_ptr_p1]    <= tok_ovf[1];
      q_length_r[wr_ptr_p1] <= tok_length[1];
      q_line_r[wr_ptr_p1]   <= line_r;
      q_column_r[wr_ptr_p1] <= tok_column[1];
      q_last_r[wr_ptr_p1]   <= tok_last[1];
    end
  end

  // queue never overfills
  `CMTS_ASSERT_IMPLY(a_fifo_bound, clk, rst_n, 1'b1, fifo_cnt_r <= CNT_BITS'(cmts_pkg::FIFO_DEPTH))
  // end marker leaves the scanner in its reset state
  `CMTS_ASSERT_NEXT(a_end_clears, clk, rst_n, step_go && at_end_r, mode_r == cmts_pkg::MODE_START && lex_len_r == 8'd0 && line_r == LINE_BITS'(1))
  // bytes inside a comment never make a token
  `CMTS_ASSERT_IMPLY(a_comment_silent, clk, rst_n, step_go && !at_end_r && (mode_r == cmts_pkg::MODE_LINE || mode_r == cmts_pkg::MODE_BLOCK || mode_r == cmts_pkg::MODE_BLOCK_STAR), !emit.slot0)
  // second slot is only used together with the first
  `CMTS_ASSERT_IMPLY(a_slot_order, clk, rst_n, emit.slot1, emit.slot0)

endmodule

[tb/c_minus_token_scanner_test.sv]
// self-checking testbench of the token scanner: byte stimulus, token prediction and compare
module c_minus_token_scanner_test;
  import cmts_pkg::*;

  // one finished token as it leaves the block
  typedef struct packed {
    logic [4:0]               kind;
    logic [NUM_BITS_DEF-1:0]  number;
    logic                     overflowed;
    logic [7:0]               length;
    logic [LINE_BITS_DEF-1:0] line;
    logic [COL_BITS_DEF-1:0]  column;
    logic                     last;
  } token_t;

  // keywords packed first character highest, with their lengths
  localparam logic [47:0] KW_WORDS [6] = '{"if", "else", "int", "void", "return", "while"};
  localparam int          KW_SIZES [6] = '{2, 4, 3, 4, 6, 5};
  localparam int          KW_LIMIT     = KEYWORD_CHARS_DEF;

  // tracks the scanner state and holds the tokens still owed by the block
  class token_ledger;
    token_t                   awaited[$];
    int                       errors;
    int                       checked;
    mode_t                    mode;
    logic [LINE_BITS_DEF-1:0] line_no;
    logic [COL_BITS_DEF-1:0]  col_no;
    logic [47:0]              kw_word;
    logic [7:0]               lex_len;
    logic [NUM_BITS_DEF-1:0]  acc;
    logic                     acc_sat;

    function new();
      errors  = 0;
      checked = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode    = MODE_START;
      line_no = 1;
      col_no  = '1;
      kw_word = '0;
      lex_len = '0;
      acc     = '0;
      acc_sat = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic is_letter(logic [7:0] c);
      return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function logic is_numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function logic is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void push_token(logic [4:0] kind, logic [NUM_BITS_DEF-1:0] value, logic sat,
                             logic [7:0] len, logic [COL_BITS_DEF-1:0] col);
      token_t t;
      t.kind       = kind;
      t.number     = value;
      t.overflowed = sat;
      t.length     = len;
      t.line       = line_no;
      t.column     = col;
      t.last       = 1'b0;
      awaited.push_back(t);
    endfunction

    function void next_line();
      if (line_no != '1) line_no++;
      col_no = '1;
    endfunction

    // saturating decimal accumulate
    function void add_digit(logic [7:0] c);
      logic [NUM_BITS_DEF-1:0] d;
      d = NUM_BITS_DEF'(c - CH_ZERO);
      if (acc > ('1 - d) / 10) begin
        acc     = '1;
        acc_sat = 1'b1;
      end else begin
        acc = acc * 10 + d;
      end
    endfunction

    function logic [4:0] word_kind();
      logic [4:0] k;
      k = KIND_ID;
      if (lex_len <= KW_LIMIT) begin
        for (int i = 0; i < 6; i++) begin
          if (lex_len == KW_SIZES[i] && kw_word == KW_WORDS[i]) k = KIND_IF + 5'(i);
        end
      end
      return k;
    endfunction

    // emit whatever token the current mode is holding
    function void flush_pending(logic [COL_BITS_DEF-1:0] col);
      case (mode)
        MODE_ID:    push_token(word_kind(), '0, 1'b0, lex_len, col);
        MODE_NUM:   push_token(KIND_NUM, acc, acc_sat, lex_len, col);
        MODE_MINUS: push_token(KIND_MINUS, '0, 1'b0, 8'd1, col);
        MODE_PLUS:  push_token(KIND_PLUS, '0, 1'b0, 8'd1, col);
        MODE_LT:    push_token(KIND_LT, '0, 1'b0, 8'd1, col);
        MODE_GT:    push_token(KIND_GT, '0, 1'b0, 8'd1, col);
        MODE_EQ:    push_token(KIND_ASSIGN, '0, 1'b0, 8'd1, col);
        MODE_BANG:  push_token(KIND_ERROR, '0, 1'b0, 8'd1, col);
        MODE_SLASH: push_token(KIND_SLASH, '0, 1'b0, 8'd1, col);
        default: ;
      endcase
      mode = MODE_START;
    endfunction

    // byte seen with nothing pending
    function void take_first(logic [7:0] c);
      case (c)
        CH_SEMI:  push_token(KIND_SEMI, '0, 1'b0, 8'd1, col_no);
        CH_COMMA: push_token(KIND_COMMA, '0, 1'b0, 8'd1, col_no);
        CH_LPAR:  push_token(KIND_LPAREN, '0, 1'b0, 8'd1, col_no);
        CH_RPAR:  push_token(KIND_RPAREN, '0, 1'b0, 8'd1, col_no);
        CH_LBRK:  push_token(KIND_LBRACKET, '0, 1'b0, 8'd1, col_no);
        CH_RBRK:  push_token(KIND_RBRACKET, '0, 1'b0, 8'd1, col_no);
        CH_LBRC:  push_token(KIND_LBRACE, '0, 1'b0, 8'd1, col_no);
        CH_RBRC:  push_token(KIND_RBRACE, '0, 1'b0, 8'd1, col_no);
        CH_STAR:  push_token(KIND_STAR, '0, 1'b0, 8'd1, col_no);
        CH_MINUS: mode = MODE_MINUS;
        CH_PLUS:  mode = MODE_PLUS;
        CH_LT:    mode = MODE_LT;
        CH_GT:    mode = MODE_GT;
        CH_EQ:    mode = MODE_EQ;
        CH_BANG:  mode = MODE_BANG;
        CH_SLASH: mode = MODE_SLASH;
        default: begin
          if (is_blank(c)) begin
            if (c == CH_NL) next_line();
          end else if (is_letter(c)) begin
            mode    = MODE_ID;
            lex_len = 8'd1;
            kw_word = {40'b0, c};
          end else if (is_numeral(c)) begin
            mode    = MODE_NUM;
            lex_len = 8'd1;
            acc     = '0;
            acc_sat = 1'b0;
            add_digit(c);
          end else begin
            push_token(KIND_ERROR, '0, 1'b0, 8'd1, col_no);
          end
        end
      endcase
    endfunction

    // second byte of a possible two-byte operator
    function logic close_pair(logic [7:0] c, logic [7:0] want, logic [4:0] kind);
      if (c != want) return 1'b0;
      push_token(kind, '0, 1'b0, 8'd2, col_no);
      mode = MODE_START;
      return 1'b1;
    endfunction

    // accepted request: advance the state and queue the tokens it owes
    function void take_byte(logic [7:0] c, logic end_mark);
      int                      first;
      logic [COL_BITS_DEF-1:0] prev;
      logic                    consumed;
      first    = awaited.size();
      consumed = 1'b0;
      if (end_mark) begin
        flush_pending(col_no);
        push_token(KIND_END, '0, 1'b0, 8'd0, col_no);
        clear_state();
      end else begin
        col_no = col_no + 1'b1;
        prev   = col_no - 1'b1;
        case (mode)
          MODE_ID: begin
            if (is_letter(c) || is_numeral(c)) begin
              if (lex_len < KW_LIMIT) kw_word = {kw_word[39:0], c};
              if (lex_len != 8'hFF) lex_len++;
              consumed = 1'b1;
            end
          end
          MODE_NUM: begin
            if (is_numeral(c)) begin
              add_digit(c);
              if (lex_len != 8'hFF) lex_len++;
              consumed = 1'b1;
            end
          end
          MODE_MINUS: consumed = close_pair(c, CH_MINUS, KIND_DEC);
          MODE_PLUS:  consumed = close_pair(c, CH_PLUS, KIND_INC);
          MODE_LT:    consumed = close_pair(c, CH_EQ, KIND_LE);
          MODE_GT:    consumed = close_pair(c, CH_EQ, KIND_GE);
          MODE_EQ:    consumed = close_pair(c, CH_EQ, KIND_EQ);
          MODE_BANG:  consumed = close_pair(c, CH_EQ, KIND_NE);
          MODE_SLASH: begin
            if (c == CH_STAR) begin
              mode     = MODE_BLOCK;
              consumed = 1'b1;
            end else if (c == CH_SLASH) begin
              mode     = MODE_LINE;
              consumed = 1'b1;
            end
          end
          MODE_LINE: begin
            if (c == CH_NL) begin
              next_line();
              mode = MODE_START;
            end
            consumed = 1'b1;
          end
          MODE_BLOCK: begin
            if (c == CH_NL) next_line();
            else if (c == CH_STAR) mode = MODE_BLOCK_STAR;
            consumed = 1'b1;
          end
          MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) begin
              mode = MODE_START;
            end else if (c == CH_NL) begin
              next_line();
              mode = MODE_BLOCK;
            end else if (c != CH_STAR) begin
              mode = MODE_BLOCK;
            end
            consumed = 1'b1;
          end
          default: mode = MODE_START;
        endcase
        if (!consumed) begin
          flush_pending(prev);
          take_first(c);
        end
      end
      if (awaited.size() > first) awaited[awaited.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("token %0d %s got %0d expected %0d",
                                  checked, name, got, want));
      end
    endtask

    // accepted token against the oldest one owed
    task match_token(token_t got);
      token_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("token %0d kind %0d arrived with none owed",
                                  checked, got.kind));
      end else begin
        want = awaited.pop_front();
        compare_field("kind", 32'(got.kind), 32'(want.kind));
        compare_field("number", 32'(got.number), 32'(want.number));
        compare_field("overflowed", 32'(got.overflowed), 32'(want.overflowed));
        compare_field("length", 32'(got.length), 32'(want.length));
        compare_field("line", 32'(got.line), 32'(want.line));
        compare_field("column", 32'(got.column), 32'(want.column));
        compare_field("last", 32'(got.last), 32'(want.last));
      end
      checked++;
    endtask

    task close_out();
      if (awaited.size() != 0) begin
        report_mismatch($sformatf("%0d tokens never arrived", awaited.size()));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  int          idle_pct;
  int          stall_pct;
  int          sent_count;
  token_t      seen;
  token_ledger ledger;

  string kw_names [6] = '{"if", "else", "int", "void", "return", "while"};
  string op_texts [21] = '{"-", "--", "+", "++", "<", "<=", ">", ">=", "=", "==", "!=",
                           "*", "/", ";", ",", "(", ")", "[", "]", "{", "}"};
  // bytes that make comment bodies interesting: stars, slashes, line breaks
  logic [7:0] comment_bytes [8] = '{CH_STAR, CH_SLASH, CH_NL, CH_SPACE, CH_LC_A,
                                    CH_ZERO, CH_STAR, CH_BANG};

  cmts_byte_if in_if ();
  cmts_tok_if  out_if ();

  c_minus_token_scanner i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_byte(in_if),
    .out_tok(out_if)
  );

  always #4 clk = ~clk;

  // receiver: ready changes on the falling edge, stalling at the phase's rate
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes are sampled on the rising edge; tokens leave before
  // any request accepted on the same edge can have produced them
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.kind       = out_if.kind;
        seen.number     = out_if.number;
        seen.overflowed = out_if.overflowed;
        seen.length     = out_if.length;
        seen.line       = out_if.line;
        seen.column     = out_if.column;
        seen.last       = out_if.last;
        ledger.match_token(seen);
      end
      if (in_if.valid && in_if.ready) ledger.take_byte(in_if.ch, in_if.at_end);
    end
  end

  // one request; entered and left on a falling edge, valid stays high between
  // back-to-back requests
  task automatic push_byte(input logic [7:0] c, input logic end_mark);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.ch     <= c;
    in_if.at_end <= end_mark;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // end marker; the byte beside it is ignored so it is random
  task automatic send_end();
    push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // sender rests until every owed token has been taken
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_letter();
    if ($urandom_range(1)) return CH_LC_A + 8'($urandom_range(25));
    return CH_UC_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] any_alnum();
    if ($urandom_range(3) == 0) return CH_ZERO + 8'($urandom_range(9));
    return any_letter();
  endfunction

  // one piece of plausible source, with some noise and broken pieces
  task automatic send_fragment();
    int pick;
    int n;
    logic [7:0] blanks [6];
    blanks = '{CH_SPACE, CH_TAB, CH_NL, 8'h0B, 8'h0C, CH_CR};
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_text(kw_names[$urandom_range(5)]);
    end else if (pick < 25) begin
      // mostly short names, now and then one past the keyword limit
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      push_byte(any_letter(), 1'b0);
      repeat (n) push_byte(any_alnum(), 1'b0);
    end else if (pick < 35) begin
      n = $urandom_range(1, 12);
      repeat (n) push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    end else if (pick < 55) begin
      send_text(op_texts[$urandom_range(20)]);
    end else if (pick < 72) begin
      push_byte(blanks[$urandom_range(5)], 1'b0);
    end else if (pick < 77) begin
      send_text("//");
      repeat ($urandom_range(6)) push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      if ($urandom_range(3) != 0) push_byte(CH_NL, 1'b0);
    end else if (pick < 83) begin
      send_text("/*");
      repeat ($urandom_range(8)) push_byte(comment_bytes[$urandom_range(7)], 1'b0);
      if ($urandom_range(3) != 0) send_text("*/");
    end else if (pick < 87) begin
      push_byte(CH_BANG, 1'b0);
    end else if (pick < 94) begin
      push_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      send_end();
    end
  endtask

  // random part of one idling setting
  task automatic run_phase(input int idle, input int stall, input int count);
    int goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = sent_count + count;
    while (sent_count < goal) send_fragment();
    send_end();
    hold_until_drained();
  endtask

  // run limit well above the slowest passing run
  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    ledger       = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    in_if.at_end = 1'b0;
    out_if.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    sent_count   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // keyword, lone bang, two-byte operator, number, block comment whose
    // opening star does not close it, star, stray bytes at both ends of the
    // range, then a line comment still open at the end
    send_text("while!x<=9/*/*/*");
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    send_text("//");
    send_end();
    hold_until_drained();

    // number edges: largest value, one past it, and a long run of nines
    send_text("4294967295 4294967296 99999999999999;");
    // length saturation on a name just past the length limit
    repeat (258) push_byte(CH_LC_Z, 1'b0);
    push_byte(CH_SEMI, 1'b0);
    // block comment left open at the end
    send_text("/*x");
    send_end();
    hold_until_drained();

    run_phase(0, 0, 30);
    run_phase(54, 0, 30);
    run_phase(0, 54, 30);
    run_phase(13, 13, 30);

    in_if.valid <= 1'b0;
    for (int k = 0; k < 5000 && ledger.pending() != 0; k++) @(negedge clk);
    repeat (20) @(negedge clk);
    ledger.close_out();
    if (ledger.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cmts_pkg.sv
hdl/cmts_byte_if.sv
hdl/cmts_tok_if.sv
hdl/cmts_step.sv
hdl/c_minus_token_scanner.sv
tb/c_minus_token_scanner_test.sv
